// ===== src/sarp_pkg.sv =====
package sarp_pkg;

  localparam int HDR_BYTES = 46;
  localparam int LEN_W = 7;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_RECORD,
    PH_DATA,
    PH_DRAIN,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    EV_CHAR,
    EV_DESC,
    EV_ACCEPT,
    EV_REJECT
  } ev_t;

  typedef enum logic [2:0] {
    RSN_SHORT,
    RSN_SIG,
    RSN_NAME,
    RSN_NEG,
    RSN_EMPTY
  } rsn_t;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_ACCEPT,
    FIN_REJECT
  } fin_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FETCH,
    B_CHAR,
    B_DESC,
    B_FINAL
  } bstate_t;

  localparam logic [0:0] REG_SPAN = 1'b0;
  localparam logic [0:0] REG_BASE = 1'b1;

  typedef struct packed {
    logic              has_member;
    logic [15:0]       idx;
    logic [31:0]       hdr_ofs;
    logic [31:0]       data_ofs;
    logic [30:0]       size;
    logic [LEN_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    fin_t              fin;
    logic [31:0]       asz;
    rsn_t              reason;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [LEN_W-1:0]  addr;
    logic [7:0]        data;
  } name_wr_t;

  function automatic logic hdr_ok(input logic [5:0] p, input logic [7:0] b);
    logic ok;
    case (p)
      6'd0:    ok = (b == "S");
      6'd1:    ok = (b == "C");
      6'd2:    ok = (b == "I");
      6'd3:    ok = (b == "1") || (b == "2");
      6'd4:    ok = (b == "0");
      6'd5:    ok = (b == "0");
      6'd6:    ok = (b == " ");
      6'd7:    ok = (b == "-");
      6'd40:   ok = (b == "n");
      6'd41:   ok = (b == "d");
      6'd42:   ok = (b == ".");
      6'd43:   ok = (b == 8'h0D);
      6'd44:   ok = (b == 8'h0A);
      6'd45:   ok = (b == 8'h1A);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic forbidden(input logic [7:0] b);
    return (b < 8'h20) || (b == 8'h7F) || (b == "/") || (b == ":") || (b == "*") ||
           (b == "?") || (b == 8'h22) || (b == "<") || (b == ">") || (b == "|");
  endfunction

  // component length saturates at 3, dots means every char so far was a dot
  function automatic logic comp_bad(input logic [1:0] clen, input logic dots);
    return (clen == 2'd0) || ((clen == 2'd1 || clen == 2'd2) && dots);
  endfunction

endpackage

// ===== src/sarp_fifo.sv =====
module sarp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sarp_pkg::job_t push_job,
  input  logic           pop,
  output sarp_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);
  import sarp_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("job queue underflow");

endmodule

// ===== src/sarp_front.sv =====
module sarp_front #(
  parameter int NAME_FIELD_BYTES = 50,
  parameter int MAX_MEMBERS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               q_full,
  input  logic               back_busy,
  output logic               job_push,
  output sarp_pkg::job_t     job,
  output sarp_pkg::name_wr_t name_wr
);
  import sarp_pkg::*;

  localparam int REC   = NAME_FIELD_BYTES + 5;
  localparam int FP_W  = $clog2(REC + 1);
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

  logic [31:0]      span_r, base_r;
  phase_t           phase_r, phase_nxt;
  logic [FP_W-1:0]  fpos_r, fpos_nxt;
  logic [31:0]      off_r, off_nxt;
  logic [LEN_W-1:0] nlen_r, nlen_nxt;
  logic             term_r, term_nxt;
  logic [31:0]      sz_r, sz_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      iend_r, iend_nxt;
  logic             bad_r, bad_nxt;
  logic             lead_r, lead_nxt;
  logic [LEN_W-1:0] strip_r, strip_nxt;
  logic [1:0]       clen_r, clen_nxt;
  logic             dots_r, dots_nxt;

  logic             in_fire, active, in_name, new_rec;
  logic [31:0]      dof;
  logic [1:0]       fsel;

  assign in_name  = (phase_r == PH_RECORD) && (fpos_r >= FP_W'(1)) &&
                    (fpos_r <= FP_W'(NAME_FIELD_BYTES));
  assign in_ready = !q_full && !(in_name && back_busy);
  assign in_fire  = in_valid && in_ready;
  assign active   = (phase_r != PH_DONE) && (off_r < span_r);
  assign dof      = off_r + 32'd1;
  assign fsel     = 2'(fpos_r - FP_W'(NAME_FIELD_BYTES + 1));

  always_comb begin
    phase_nxt = phase_r;
    fpos_nxt  = fpos_r;
    off_nxt   = off_r;
    nlen_nxt  = nlen_r;
    term_nxt  = term_r;
    sz_nxt    = sz_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    iend_nxt  = iend_r;
    bad_nxt   = bad_r;
    lead_nxt  = lead_r;
    strip_nxt = strip_r;
    clen_nxt  = clen_r;
    dots_nxt  = dots_r;
    new_rec   = 1'b0;
    name_wr   = '{we: 1'b0, addr: nlen_r, data: in_data_byte};
    job       = '{has_member: 1'b0, idx: 16'(cnt_r),
                  hdr_ofs: 32'(base_r + off_r - 32'(REC - 1)),
                  data_ofs: base_r + dof, size: sz_r[30:0],
                  start: strip_r, len: nlen_r - strip_r,
                  fin: FIN_NONE, asz: 32'd0, reason: RSN_SHORT};

    if (in_fire && active) begin
      off_nxt = dof;
      case (phase_r)
        PH_HEADER: begin
          if (off_r == 32'd0 && span_r < 32'(HDR_BYTES + REC)) begin
            phase_nxt  = PH_DONE;
            job.fin    = FIN_REJECT;
            job.reason = RSN_SHORT;
          end else if (!hdr_ok(off_r[5:0], in_data_byte)) begin
            phase_nxt  = PH_DONE;
            job.fin    = FIN_REJECT;
            job.reason = RSN_SIG;
          end else if (dof >= 32'(HDR_BYTES)) begin
            iend_nxt = 32'(HDR_BYTES);
            new_rec  = 1'b1;
          end
        end
        PH_RECORD: begin
          if (in_name) begin
            if (!term_r) begin
              if (in_data_byte == 8'h00) begin
                term_nxt = 1'b1;
              end else begin
                name_wr.we = 1'b1;
                nlen_nxt   = nlen_r + LEN_W'(1);
                if (in_data_byte == "\\") begin
                  if (lead_r) begin
                    strip_nxt = strip_r + LEN_W'(1);
                  end else begin
                    bad_nxt  = bad_r | comp_bad(clen_r, dots_r);
                    clen_nxt = 2'd0;
                    dots_nxt = 1'b1;
                  end
                end else begin
                  lead_nxt = 1'b0;
                  bad_nxt  = bad_r | forbidden(in_data_byte);
                  clen_nxt = (clen_r == 2'd3) ? 2'd3 : clen_r + 2'd1;
                  dots_nxt = dots_r & (in_data_byte == ".");
                end
              end
            end
          end else if (fpos_r > FP_W'(NAME_FIELD_BYTES)) begin
            sz_nxt = sz_r | (32'(in_data_byte) << {fsel, 3'b000});
          end
          fpos_nxt = fpos_r + FP_W'(1);
          if (fpos_r == FP_W'(REC - 1)) begin
            job.size = sz_nxt[30:0];
            if (bad_r || comp_bad(clen_r, dots_r)) begin
              phase_nxt  = PH_DONE;
              job.fin    = FIN_REJECT;
              job.reason = RSN_NAME;
            end else if (sz_nxt[31]) begin
              phase_nxt  = PH_DONE;
              job.fin    = FIN_REJECT;
              job.reason = RSN_NEG;
            end else if (sz_nxt > span_r - dof) begin
              phase_nxt = PH_DRAIN;
            end else begin
              job.has_member = 1'b1;
              cnt_nxt  = cnt_r + CNT_W'(1);
              iend_nxt = dof + sz_nxt;
              if (cnt_r == CNT_W'(MAX_MEMBERS - 1)) begin
                phase_nxt = PH_DONE;
                job.fin   = FIN_ACCEPT;
                job.asz   = iend_nxt;
              end else if (sz_nxt == 32'd0) begin
                new_rec = 1'b1;
              end else begin
                phase_nxt = PH_DATA;
                rem_nxt   = sz_nxt;
              end
            end
          end
        end
        PH_DATA: begin
          if (rem_r <= 32'd1) begin
            new_rec = 1'b1;
          end else begin
            rem_nxt = rem_r - 32'd1;
          end
        end
        default: begin
        end
      endcase

      if (new_rec) begin
        phase_nxt = PH_RECORD;
        fpos_nxt  = '0;
        nlen_nxt  = '0;
        term_nxt  = 1'b0;
        sz_nxt    = '0;
        rem_nxt   = '0;
        bad_nxt   = 1'b0;
        lead_nxt  = 1'b1;
        strip_nxt = '0;
        clen_nxt  = 2'd0;
        dots_nxt  = 1'b1;
      end

      // last byte of the span closes the walk
      if (phase_nxt != PH_DONE && dof == span_r) begin
        phase_nxt = PH_DONE;
        if (cnt_nxt == '0) begin
          job.fin    = FIN_REJECT;
          job.reason = RSN_EMPTY;
        end else begin
          job.fin = FIN_ACCEPT;
          job.asz = iend_nxt;
        end
      end
    end
  end

  assign job_push = job.has_member || (job.fin != FIN_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= '0;
      base_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_SPAN) span_r <= cfg_wdata;
      else                       base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      phase_r <= PH_HEADER;
      fpos_r  <= '0;
      off_r   <= '0;
      nlen_r  <= '0;
      term_r  <= 1'b0;
      sz_r    <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
      iend_r  <= 32'(HDR_BYTES);
      bad_r   <= 1'b0;
      lead_r  <= 1'b1;
      strip_r <= '0;
      clen_r  <= 2'd0;
      dots_r  <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      fpos_r  <= fpos_nxt;
      off_r   <= off_nxt;
      nlen_r  <= nlen_nxt;
      term_r  <= term_nxt;
      sz_r    <= sz_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      iend_r  <= iend_nxt;
      bad_r   <= bad_nxt;
      lead_r  <= lead_nxt;
      strip_r <= strip_nxt;
      clen_r  <= clen_nxt;
      dots_r  <= dots_nxt;
    end
  end

  a_name_guard: assert property (@(posedge clk) disable iff (!rst_n)
    name_wr.we |-> !back_busy) else $error("name store written during emission");

endmodule

// ===== src/sarp_back.sv =====
module sarp_back #(
  parameter int NAME_FIELD_BYTES = 50
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sarp_pkg::name_wr_t   name_wr,
  input  logic                 q_empty,
  input  sarp_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_event_res,
  output logic [7:0]           out_name_char,
  output logic [15:0]          out_member_index,
  output logic [31:0]          out_rec_pos,
  output logic [31:0]          out_payload_pos,
  output logic [30:0]          out_member_size,
  output logic [31:0]          out_total_bytes,
  output logic [2:0]           out_reject_reason,
  output logic                 out_last
);
  import sarp_pkg::*;

  localparam int AW = (NAME_FIELD_BYTES > 1) ? $clog2(NAME_FIELD_BYTES) : 1;

  logic [7:0]       mem [NAME_FIELD_BYTES];
  logic [7:0]       rd_q;
  bstate_t          st_r, st_nxt;
  job_t             job_r;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] rd_addr;
  logic             slot_free, load;
  logic             ov_r;
  logic [1:0]       ev_r, ev_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic             has_r, has_nxt;
  logic [31:0]      asz_r, asz_nxt;
  logic [2:0]       rsn_r, rsn_nxt;
  logic             last_r, last_nxt;

  assign rd_addr   = job_r.start + i_r;
  assign slot_free = !ov_r || out_ready;
  assign busy      = (st_r != B_IDLE);

  always_ff @(posedge clk) begin
    if (name_wr.we) begin
      mem[name_wr.addr[AW-1:0]] <= name_wr.data;
    end
    rd_q <= mem[rd_addr[AW-1:0]];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:  if (!q_empty && slot_free) st_nxt = q_job.has_member ? B_FETCH : B_FINAL;
      B_FETCH: st_nxt = B_CHAR;
      B_CHAR:  if (slot_free) st_nxt = (i_r + LEN_W'(1) == job_r.len) ? B_DESC : B_FETCH;
      B_DESC:  if (slot_free) st_nxt = (job_r.fin == FIN_NONE) ? B_IDLE : B_FINAL;
      B_FINAL: if (slot_free) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load     = 1'b0;
    i_nxt    = i_r;
    ev_nxt   = EV_CHAR;
    ch_nxt   = 8'h00;
    has_nxt  = 1'b0;
    asz_nxt  = 32'd0;
    rsn_nxt  = 3'(RSN_SHORT);
    last_nxt = 1'b0;
    case (st_r)
      B_IDLE: begin
        q_pop = !q_empty && slot_free;
        i_nxt = '0;
      end
      B_CHAR: begin
        load    = slot_free;
        ev_nxt  = EV_CHAR;
        ch_nxt  = (rd_q == "\\") ? "/" : rd_q;
        has_nxt = 1'b1;
        if (slot_free) i_nxt = i_r + LEN_W'(1);
      end
      B_DESC: begin
        load     = slot_free;
        ev_nxt   = EV_DESC;
        has_nxt  = 1'b1;
        last_nxt = (job_r.fin == FIN_NONE);
      end
      B_FINAL: begin
        load     = slot_free;
        ev_nxt   = (job_r.fin == FIN_ACCEPT) ? EV_ACCEPT : EV_REJECT;
        asz_nxt  = (job_r.fin == FIN_ACCEPT) ? job_r.asz : 32'd0;
        rsn_nxt  = (job_r.fin == FIN_ACCEPT) ? 3'(RSN_SHORT) : 3'(job_r.reason);
        last_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    if (q_pop) job_r <= q_job;
    if (load) begin
      ev_r   <= ev_nxt;
      ch_r   <= ch_nxt;
      has_r  <= has_nxt;
      asz_r  <= asz_nxt;
      rsn_r  <= rsn_nxt;
      last_r <= last_nxt;
    end
  end

  // member fields of job_r hold until the next pop, which waits for idle
  // and a free result register
  assign out_valid         = ov_r;
  assign out_event_res     = ev_r;
  assign out_name_char     = ch_r;
  assign out_member_index  = has_r ? job_r.idx : 16'd0;
  assign out_rec_pos       = has_r ? job_r.hdr_ofs : 32'd0;
  assign out_payload_pos   = has_r ? job_r.data_ofs : 32'd0;
  assign out_member_size   = has_r ? job_r.size : 31'd0;
  assign out_total_bytes   = asz_r;
  assign out_reject_reason = rsn_r;
  assign out_last          = last_r;

  a_char_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_CHAR) |-> ($past(st_r) == B_FETCH || $past(st_r) == B_CHAR))
    else $error("char emitted without fetch");

endmodule

// ===== src/stored_archive_record_parser_unit.sv =====
// channel  | direction | handshake            | payload
// in_      | input     | in_valid/in_ready    | in_data_byte
// out_     | output    | out_valid/out_ready  | event, name char, offsets, sizes, last
// cfg_     | input     | cfg_we               | cfg_index, cfg_wdata
//
// one archive byte per cycle; name bytes wait while the back end is busy
// back end: takes a job from idle, then a fetch step and a char step per name char (store read),
// then descriptor and final result steps as the job needs, plus any result-side hold-off
// a job is taken only when the result register is free
// input also waits while the two-entry job queue is full
// reset is synchronous active low; a config write restarts the walk
module stored_archive_record_parser_unit #(
  parameter int NAME_FIELD_BYTES = 50,
  parameter int MAX_MEMBERS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_name_char,
  output logic [15:0] out_member_index,
  output logic [31:0] out_rec_pos,
  output logic [31:0] out_payload_pos,
  output logic [30:0] out_member_size,
  output logic [31:0] out_total_bytes,
  output logic [2:0]  out_reject_reason,
  output logic        out_last
);
  import sarp_pkg::*;

  job_t     push_job, pop_job;
  name_wr_t name_wr;
  logic     push, pop, q_full, q_empty, back_act, back_busy;

  assign back_busy = back_act || !q_empty;

  sarp_front #(
    .NAME_FIELD_BYTES(NAME_FIELD_BYTES),
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_data_byte),
    .q_full(q_full), .back_busy(back_busy),
    .job_push(push), .job(push_job), .name_wr(name_wr)
  );

  sarp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_job(push_job),
    .pop(pop), .pop_job(pop_job),
    .full(q_full), .empty(q_empty)
  );

  sarp_back #(
    .NAME_FIELD_BYTES(NAME_FIELD_BYTES)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .name_wr(name_wr),
    .q_empty(q_empty), .q_job(pop_job), .q_pop(pop), .busy(back_act),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_res(out_event_res), .out_name_char(out_name_char),
    .out_member_index(out_member_index), .out_rec_pos(out_rec_pos),
    .out_payload_pos(out_payload_pos), .out_member_size(out_member_size),
    .out_total_bytes(out_total_bytes), .out_reject_reason(out_reject_reason),
    .out_last(out_last)
  );

endmodule
